>>> sv/ssng_pkg.sv
// ----------------------------------------------------------------------------
// ssng_pkg
// Widths, register indexes and arithmetic constants of the step sequencer
// note generator.
// ----------------------------------------------------------------------------
package ssng_pkg;

  localparam int MAX_RATCHETS = 16;
  localparam int MAX_STEPS    = 4096;
  localparam int MAX_LANES    = 16;

  localparam int LANE_W  = $clog2(MAX_LANES);
  localparam int STEP_W  = $clog2(MAX_STEPS);
  localparam int RAT_W   = $clog2(MAX_RATCHETS);
  localparam int RCNT_W  = RAT_W + 1;
  localparam int PITCH_W = 7;
  localparam int VEL_W   = 7;
  localparam int THR_W   = 14;
  localparam int LEN_W   = 24;
  localparam int SWING_W = 11;
  localparam int SEED_W  = 32;
  localparam int OFFS_W  = 40;
  localparam int START_W = 42;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_STEP_LENGTH     = 2'd0;
  localparam cfg_index_t REG_SWING_AMOUNT    = 2'd1;
  localparam cfg_index_t REG_RANDOM_SEED     = 2'd2;
  localparam cfg_index_t REG_TIMELINE_OFFSET = 2'd3;

  localparam logic [LEN_W-1:0]   STEP_LENGTH_RST = 24'd6000;

  localparam logic [31:0] MIX_C0 = 32'h9e3779b9;
  localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
  localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

  // floor(h / 10000) == (h * RECIP_10000) >> RECIP_SHIFT for every 32-bit h
  localparam logic [31:0] RECIP_10000 = 32'd3518437209;
  localparam int          RECIP_SHIFT = 45;
  localparam logic [31:0] PROB_MOD    = 32'd10000;

  localparam logic signed [SWING_W-1:0] SWING_MAX = 11'sd512;
  localparam logic signed [SWING_W-1:0] SWING_MIN = -11'sd512;
  localparam int                        SWING_FRAC = 10;

  localparam logic [VEL_W-1:0] VEL_MAX    = 7'd127;
  localparam logic [VEL_W:0]   ACCENT_ADD = 8'd16;

endpackage

>>> sv/ssng_if.sv
// ----------------------------------------------------------------------------
// ssng channel interfaces
// Step event, note and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssng_step_if
  import ssng_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LANE_W-1:0]  lane_number;
  logic [STEP_W-1:0]  step_number;
  logic               step_enabled;
  logic [RCNT_W-1:0]  ratchet_count;
  logic [PITCH_W-1:0] step_pitch;
  logic [PITCH_W-1:0] lane_pitch;
  logic [VEL_W-1:0]   step_velocity;
  logic               accent_flag;
  logic               tie_flag;
  logic               slide_flag;
  logic [THR_W-1:0]   prob_threshold;

  modport source (
    output valid, lane_number, step_number, step_enabled, ratchet_count, step_pitch,
           lane_pitch, step_velocity, accent_flag, tie_flag, slide_flag, prob_threshold,
    input  ready
  );
  modport sink (
    input  valid, lane_number, step_number, step_enabled, ratchet_count, step_pitch,
           lane_pitch, step_velocity, accent_flag, tie_flag, slide_flag, prob_threshold,
    output ready
  );
endinterface

interface ssng_note_if
  import ssng_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LANE_W-1:0]  note_lane;
  logic [STEP_W-1:0]  note_step;
  logic [RAT_W-1:0]   note_ratchet;
  logic [START_W-1:0] note_start;
  logic [LEN_W-1:0]   note_length;
  logic [PITCH_W-1:0] note_pitch;
  logic [VEL_W-1:0]   note_velocity;
  logic               note_slide;
  logic               last_note;

  modport source (
    output valid, note_lane, note_step, note_ratchet, note_start, note_length,
           note_pitch, note_velocity, note_slide, last_note,
    input  ready
  );
  modport sink (
    input  valid, note_lane, note_step, note_ratchet, note_start, note_length,
           note_pitch, note_velocity, note_slide, last_note,
    output ready
  );
endinterface

interface ssng_cfg_if
  import ssng_pkg::*;
();
  logic                  valid;
  logic                  ready;
  cfg_index_t            index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/step_sequencer_note_generator.sv
// ----------------------------------------------------------------------------
// step_sequencer_note_generator
// Turns one sequencer step event into its ratchet notes with swing,
// probability, pitch fallback and accent.
// ----------------------------------------------------------------------------
// One step event is taken while the block is idle; it then works alone on that
// event: setup states MULA, MULB and SWING around the shared 32x32 multiplier,
// a bit-serial divider for the ratchet length, the hash states HMIX, HMUL,
// HREM and HCMP for each ratchet for the probability hash mod 10000, and one
// ratchet per cycle to emit, slower when the note sink stalls. Notes leave
// through an output register, so the next event can be taken while the last
// note still waits. A disabled step, or a step length of zero, gives no notes
// and the block stays idle.
// ----------------------------------------------------------------------------
module step_sequencer_note_generator
  import ssng_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ssng_cfg_if.sink    cfg,
  ssng_step_if.sink   step,
  ssng_note_if.source note
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MULA  = 9'b000000010,
    S_MULB  = 9'b000000100,
    S_SWING = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_HMIX  = 9'b000100000,
    S_HMUL  = 9'b001000000,
    S_HREM  = 9'b010000000,
    S_HCMP  = 9'b100000000
  } state_t;

  localparam int DCNT_W = $clog2(LEN_W);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(LEN_W - 1);
  localparam int PMUL_W = LEN_W + SWING_W - 1;

  state_t state;
  logic   emitting;

  logic [LEN_W-1:0]           step_length;
  logic signed [SWING_W-1:0]  swing_amount;
  logic [SEED_W-1:0]          random_seed;
  logic [OFFS_W-1:0]          timeline_offset;

  logic [LANE_W-1:0]  lane;
  logic [STEP_W-1:0]  stp;
  logic [RCNT_W-1:0]  rats;
  logic [PITCH_W-1:0] pitch;
  logic [VEL_W-1:0]   vel;
  logic               tie;
  logic               slide;
  logic [THR_W-1:0]   thr;

  logic [31:0]          hbase;
  logic [31:0]          h;
  logic [63:0]          prod;
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [STEP_W+LEN_W-1:0] start_raw;
  logic [START_W-1:0]   base;
  logic [START_W-1:0]   acc;
  logic [LEN_W-1:0]     quot;
  logic [RAT_W-1:0]     rem;
  logic [DCNT_W-1:0]    dcnt;
  logic [RAT_W-1:0]     rcnt;
  logic [MAX_RATCHETS-1:0] keep;

  logic [RCNT_W-1:0]  in_rats;
  logic [VEL_W:0]     vel_sum;
  logic [9:0]         swing_abs;
  logic [SWING_W-1:0] swing_neg;
  logic [PMUL_W:0]    mag_sum;
  logic [START_W-1:0] mag;
  logic [START_W-1:0] swing_term;
  logic [RAT_W:0]     div_trial;
  logic               div_ge;
  logic [31:0]        hmod;
  logic               rcnt_last;
  logic [MAX_RATCHETS-1:0] keep_above;
  logic               out_free;

  function automatic logic [31:0] mix(input logic [31:0] hv, input logic [31:0] x,
                                      input logic [31:0] c);
    mix = hv ^ (x + c + (hv << 6) + (hv >> 2));
  endfunction

  assign cfg.ready  = 1'b1;
  assign step.ready = (state == S_IDLE) && !emitting;
  assign out_free   = !note.valid || note.ready;

  always_comb begin
    if (step.ratchet_count == '0) begin
      in_rats = RCNT_W'(1);
    end else if (step.ratchet_count > RCNT_W'(MAX_RATCHETS)) begin
      in_rats = RCNT_W'(MAX_RATCHETS);
    end else begin
      in_rats = step.ratchet_count;
    end
    vel_sum = {1'b0, step.step_velocity} + ACCENT_ADD;
  end

  always_comb begin
    swing_neg = -swing_amount;
    if (swing_amount > SWING_MAX || swing_amount < SWING_MIN) begin
      swing_abs = 10'd512;
    end else if (swing_amount[SWING_W-1]) begin
      swing_abs = swing_neg[9:0];
    end else begin
      swing_abs = swing_amount[9:0];
    end
    mag_sum = {1'b0, prod[PMUL_W-1:0]} + (PMUL_W+1)'(512);
    mag     = START_W'(mag_sum >> SWING_FRAC);
    if (!stp[0]) begin
      swing_term = '0;
    end else if (swing_amount[SWING_W-1]) begin
      swing_term = -mag;
    end else begin
      swing_term = mag;
    end
  end

  always_comb begin
    unique case (state)
      S_MULA: begin
        mul_a = 32'(stp);
        mul_b = 32'(step_length);
      end
      S_MULB: begin
        mul_a = 32'(step_length);
        mul_b = 32'(swing_abs);
      end
      S_HMUL: begin
        mul_a = h;
        mul_b = RECIP_10000;
      end
      S_HREM: begin
        mul_a = 32'(prod[63:RECIP_SHIFT]);
        mul_b = PROB_MOD;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_trial  = {rem, quot[LEN_W-1]};
    div_ge     = div_trial >= rats;
    hmod       = h - prod[31:0];
    rcnt_last  = ({1'b0, rcnt} == rats - RCNT_W'(1));
    keep_above = keep >> rcnt;
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_length     <= STEP_LENGTH_RST;
      swing_amount    <= '0;
      random_seed     <= '0;
      timeline_offset <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_STEP_LENGTH:     step_length     <= cfg.data[LEN_W-1:0];
        REG_SWING_AMOUNT:    swing_amount    <= cfg.data[SWING_W-1:0];
        REG_RANDOM_SEED:     random_seed     <= cfg.data[SEED_W-1:0];
        REG_TIMELINE_OFFSET: timeline_offset <= cfg.data[OFFS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      emitting   <= 1'b0;
      note.valid <= 1'b0;
    end else begin
      if (emitting && keep[rcnt] && out_free) begin
        note.valid         <= 1'b1;
        note.note_lane     <= lane;
        note.note_step     <= stp;
        note.note_ratchet  <= rcnt;
        note.note_start    <= acc;
        note.note_length   <= tie ? step_length : quot;
        note.note_pitch    <= pitch;
        note.note_velocity <= vel;
        note.note_slide    <= slide;
        note.last_note     <= (keep_above[MAX_RATCHETS-1:1] == '0);
      end else if (note.ready) begin
        note.valid <= 1'b0;
      end
      if (emitting && (!keep[rcnt] || out_free)) begin
        acc  <= acc + START_W'(quot);
        rcnt <= rcnt + RAT_W'(1);
        if (rcnt_last) begin
          emitting <= 1'b0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (step.valid && step.ready) begin
            lane  <= step.lane_number;
            stp   <= step.step_number;
            rats  <= in_rats;
            pitch <= (step.step_pitch == '0) ? step.lane_pitch : step.step_pitch;
            if (step.accent_flag) begin
              vel <= (vel_sum > {1'b0, VEL_MAX}) ? VEL_MAX : vel_sum[VEL_W-1:0];
            end else begin
              vel <= step.step_velocity;
            end
            tie   <= step.tie_flag;
            slide <= step.slide_flag;
            thr   <= step.prob_threshold;
            hbase <= random_seed;
            if (step.step_enabled && step_length != '0) begin
              state <= S_MULA;
            end
          end
        end
        S_MULA: begin
          hbase <= mix(hbase, 32'(lane), MIX_C0);
          state <= S_MULB;
        end
        S_MULB: begin
          start_raw <= prod[STEP_W+LEN_W-1:0];
          hbase     <= mix(hbase, 32'(stp), MIX_C1);
          state     <= S_SWING;
        end
        S_SWING: begin
          base  <= START_W'(start_raw) + START_W'(timeline_offset) + swing_term;
          quot  <= step_length;
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          quot <= {quot[LEN_W-2:0], div_ge};
          rem  <= div_ge ? RAT_W'(div_trial - RAT_W'(rats)) : div_trial[RAT_W-1:0];
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_LAST) begin
            rcnt  <= '0;
            keep  <= '0;
            state <= S_HMIX;
          end
        end
        S_HMIX: begin
          h     <= mix(hbase, 32'(rcnt), MIX_C2);
          state <= S_HMUL;
        end
        S_HMUL: begin
          state <= S_HREM;
        end
        S_HREM: begin
          state <= S_HCMP;
        end
        S_HCMP: begin
          keep[rcnt] <= (hmod < 32'(thr));
          if (rcnt_last) begin
            rcnt     <= '0;
            acc      <= base;
            emitting <= 1'b1;
            state    <= S_IDLE;
          end else begin
            rcnt  <= rcnt + RAT_W'(1);
            state <= S_HMIX;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> dv/step_sequencer_note_generator_test.sv
// ----------------------------------------------------------------------------
// step_sequencer_note_generator_test
// Drives step events and register writes into the note generator with random
// gaps and note-side stalls. A ledger class predicts the notes of every
// accepted step event (ratchet clamp, hash probability, swing, pitch fallback,
// accent saturation, tie length) and checks each note transaction in order.
// ----------------------------------------------------------------------------
module step_sequencer_note_generator_test;
  import ssng_pkg::*;

  localparam int SETTLE_CYCLES  = 150;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [LANE_W-1:0]  lane;
    logic [STEP_W-1:0]  step_num;
    logic               enabled;
    logic [RCNT_W-1:0]  ratchets;
    logic [PITCH_W-1:0] pitch;
    logic [PITCH_W-1:0] lane_pitch;
    logic [VEL_W-1:0]   velocity;
    logic               accent;
    logic               tie;
    logic               slide;
    logic [THR_W-1:0]   threshold;
  } step_event_t;

  typedef struct packed {
    logic [LANE_W-1:0]  lane;
    logic [STEP_W-1:0]  step_num;
    logic [RAT_W-1:0]   ratchet;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic [PITCH_W-1:0] pitch;
    logic [VEL_W-1:0]   velocity;
    logic               slide;
    logic               last;
  } note_t;

  class note_ledger;
    note_t             due_notes[$];
    int                errors;
    longint            step_len;
    int                swing;
    logic [SEED_W-1:0] seed;
    longint            offset;

    function new();
      errors   = 0;
      step_len = longint'(STEP_LENGTH_RST);
      swing    = 0;
      seed     = '0;
      offset   = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      logic signed [SWING_W-1:0] sw;
      sw = data[SWING_W-1:0];
      case (idx)
        REG_STEP_LENGTH:     step_len = longint'(data[LEN_W-1:0]);
        REG_SWING_AMOUNT:    swing = int'(sw);
        REG_RANDOM_SEED:     seed = data[SEED_W-1:0];
        REG_TIMELINE_OFFSET: offset = longint'(data[OFFS_W-1:0]);
        default: ;
      endcase
    endfunction

    function logic [31:0] mix(logic [31:0] h, logic [31:0] x, logic [31:0] c);
      return h ^ (x + c + (h << 6) + (h >> 2));
    endfunction

    function bit plays(logic [LANE_W-1:0] lane, logic [STEP_W-1:0] stp, int r,
                       logic [THR_W-1:0] thr);
      logic [31:0] h;
      if (thr == 0) return 1'b0;
      if (thr >= PROB_MOD) return 1'b1;
      h = mix(seed, 32'(lane), MIX_C0);
      h = mix(h, 32'(stp), MIX_C1);
      h = mix(h, 32'(r), MIX_C2);
      return (h % PROB_MOD) < thr;
    endfunction

    // odd steps shift by step_len * swing / 1024, rounded half away from zero
    function longint swung_start(logic [STEP_W-1:0] stp);
      longint st;
      longint p;
      longint mag;
      int     s;
      st = longint'(stp) * step_len;
      if (stp[0]) begin
        s = swing;
        if (s > 512) s = 512;
        if (s < -512) s = -512;
        p = step_len * s;
        mag = ((p < 0 ? -p : p) + 512) / 1024;
        st += (p < 0) ? -mag : mag;
      end
      if (st < 0) st = 0;
      return st;
    endfunction

    function void predict_notes(step_event_t ev);
      int     rats;
      int     vel;
      int     first;
      int     r;
      longint rlen;
      longint len;
      longint base;
      note_t  n;
      if (!ev.enabled || step_len == 0) return;
      rats = ev.ratchets;
      if (rats < 1) rats = 1;
      if (rats > MAX_RATCHETS) rats = MAX_RATCHETS;
      vel = ev.velocity;
      if (ev.accent) vel = (vel + 16 > 127) ? 127 : vel + 16;
      rlen  = step_len / rats;
      len   = ev.tie ? step_len : rlen;
      base  = swung_start(ev.step_num) + offset;
      first = due_notes.size();
      for (r = 0; r < rats; r++) begin
        if (plays(ev.lane, ev.step_num, r, ev.threshold)) begin
          n.lane     = ev.lane;
          n.step_num = ev.step_num;
          n.ratchet  = r[RAT_W-1:0];
          n.start    = START_W'(base + r * rlen);
          n.length   = LEN_W'(len);
          n.pitch    = (ev.pitch == 0) ? ev.lane_pitch : ev.pitch;
          n.velocity = VEL_W'(vel);
          n.slide    = ev.slide;
          n.last     = 1'b0;
          due_notes.insert(due_notes.size(), n);
        end
      end
      if (due_notes.size() > first) due_notes[due_notes.size()-1].last = 1'b1;
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_note(note_t got);
      note_t want;
      if (due_notes.size() == 0) begin
        $error("unexpected note: lane %0d step %0d ratchet %0d",
               got.lane, got.step_num, got.ratchet);
        errors++;
        return;
      end
      want = due_notes.pop_front();
      check_field("note_lane", want.lane, got.lane);
      check_field("note_step", want.step_num, got.step_num);
      check_field("note_ratchet", want.ratchet, got.ratchet);
      check_field("note_start", want.start, got.start);
      check_field("note_length", want.length, got.length);
      check_field("note_pitch", want.pitch, got.pitch);
      check_field("note_velocity", want.velocity, got.velocity);
      check_field("note_slide", want.slide, got.slide);
      check_field("last_note", want.last, got.last);
    endfunction

    function bit wrap_up();
      if (due_notes.size() != 0) begin
        $error("%0d expected notes never arrived", due_notes.size());
        errors++;
      end
      return errors == 0;
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  bit         steady = 1'b0;
  int         idle_cycles = 0;
  note_ledger ledger;

  ssng_cfg_if  cfg_ch ();
  ssng_step_if step_ch ();
  ssng_note_if note_ch ();

  step_sequencer_note_generator uut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .step (step_ch),
    .note (note_ch)
  );

  always #10 clk = ~clk;

  function int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // note sink with random stalls
  initial begin
    int hold;
    hold = 0;
    note_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        note_ch.ready = 1'b0;
        hold--;
      end else begin
        note_ch.ready = 1'b1;
        if ($urandom_range(0, 2) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && note_ch.valid && note_ch.ready)
      ledger.check_note('{note_ch.note_lane, note_ch.note_step, note_ch.note_ratchet,
                          note_ch.note_start, note_ch.note_length, note_ch.note_pitch,
                          note_ch.note_velocity, note_ch.note_slide, note_ch.last_note});
  end

  always @(posedge clk) begin
    if (rst || (step_ch.valid && step_ch.ready) || (note_ch.valid && note_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic drive_step(step_event_t ev);
    step_ch.lane_number    = ev.lane;
    step_ch.step_number    = ev.step_num;
    step_ch.step_enabled   = ev.enabled;
    step_ch.ratchet_count  = ev.ratchets;
    step_ch.step_pitch     = ev.pitch;
    step_ch.lane_pitch     = ev.lane_pitch;
    step_ch.step_velocity  = ev.velocity;
    step_ch.accent_flag    = ev.accent;
    step_ch.tie_flag       = ev.tie;
    step_ch.slide_flag     = ev.slide;
    step_ch.prob_threshold = ev.threshold;
  endtask

  // valid stays high on return so back-to-back transactions need no toggle
  task automatic send_step(step_event_t ev);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      step_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    drive_step(ev);
    step_ch.valid = 1'b1;
    @(posedge clk);
    while (!step_ch.ready) @(posedge clk);
    ledger.predict_notes(ev);
    @(negedge clk);
  endtask

  task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    ledger.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // unused upper data bits carry junk, the block must ignore them
  task automatic configure(logic [LEN_W-1:0] len, logic signed [SWING_W-1:0] sw,
                           logic [SEED_W-1:0] sd, logic [OFFS_W-1:0] off);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    write_register(REG_STEP_LENGTH, {junk[CFG_DATA_W-1:LEN_W], len});
    write_register(REG_SWING_AMOUNT, {junk[CFG_DATA_W-1:SWING_W], sw});
    write_register(REG_RANDOM_SEED, {junk[CFG_DATA_W-1:SEED_W], sd});
    write_register(REG_TIMELINE_OFFSET, off);
  endtask

  task automatic random_config();
    logic [LEN_W-1:0] len;
    if ($urandom_range(0, 3) == 0) len = LEN_W'($urandom);
    else len = LEN_W'($urandom_range(1, 20000));
    configure(len, SWING_W'($urandom), $urandom, OFFS_W'({$urandom, $urandom}));
  endtask

  // wait for outstanding notes, then let a step that plays nothing finish
  task automatic settle();
    step_ch.valid = 1'b0;
    while (ledger.due_notes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic play(int ln, int sn, int en, int rc, int pt, int lp, int vl,
                      int ac, int ti, int sl, int th);
    step_event_t ev;
    ev.lane       = LANE_W'(ln);
    ev.step_num   = STEP_W'(sn);
    ev.enabled    = 1'(en);
    ev.ratchets   = RCNT_W'(rc);
    ev.pitch      = PITCH_W'(pt);
    ev.lane_pitch = PITCH_W'(lp);
    ev.velocity   = VEL_W'(vl);
    ev.accent     = 1'(ac);
    ev.tie        = 1'(ti);
    ev.slide      = 1'(sl);
    ev.threshold  = THR_W'(th);
    send_step(ev);
  endtask

  task automatic random_steps(int count);
    step_event_t ev;
    int          played;
    int          pick;
    played = 0;
    while (played < count) begin
      ev.lane       = LANE_W'($urandom);
      ev.step_num   = STEP_W'($urandom);
      ev.ratchets   = RCNT_W'($urandom);
      ev.pitch      = PITCH_W'($urandom);
      ev.lane_pitch = PITCH_W'($urandom);
      ev.velocity   = VEL_W'($urandom);
      ev.accent     = 1'($urandom);
      ev.tie        = 1'($urandom);
      ev.slide      = 1'($urandom);
      ev.threshold  = THR_W'($urandom_range(0, 16383));
      ev.enabled    = ($urandom_range(0, 99) >= 12);
      if (ev.enabled) begin
        if ($urandom_range(0, 99) < 70) ev.ratchets = RCNT_W'($urandom_range(0, MAX_RATCHETS));
        if ($urandom_range(0, 99) < 20) ev.pitch = '0;
        pick = $urandom_range(0, 99);
        if (pick < 10) ev.threshold = '0;
        else if (pick < 35) ev.threshold = THR_W'($urandom_range(10000, 16383));
        else ev.threshold = THR_W'($urandom_range(1, 9999));
      end
      send_step(ev);
      if (ev.enabled) played++;
    end
  endtask

  initial begin
    ledger = new();
    drive_step('0);
    step_ch.valid = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_STEP_LENGTH;
    cfg_ch.data   = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // reset settings
    play(3, 10, 0, 4, 60, 50, 100, 1, 1, 1, 10000);
    play(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 10000);
    play(15, 4095, 1, 31, 127, 127, 127, 1, 1, 1, 16383);
    play(5, 7, 1, 16, 64, 10, 80, 0, 0, 0, 0);
    play(6, 8, 1, 16, 64, 0, 80, 0, 0, 1, 1);
    play(7, 9, 1, 16, 33, 0, 90, 1, 0, 0, 9999);
    play(2, 3, 1, 3, 0, 72, 90, 0, 0, 0, 10000);
    play(1, 2, 1, 2, 40, 0, 100, 1, 0, 0, 10000);
    play(4, 5, 1, 4, 50, 0, 70, 0, 1, 1, 10000);
    play(9, 11, 1, 16, 20, 30, 40, 0, 0, 0, 5000);
    play(10, 12, 1, 17, 21, 31, 41, 1, 0, 1, 10000);
    random_steps(30);
    settle();

    // one-sample steps, untied ratchets collapse to zero length
    steady = 1'b1;
    configure(24'd1, SWING_MAX, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    play(15, 1, 1, 16, 100, 0, 127, 1, 0, 1, 10000);
    play(0, 4095, 1, 16, 0, 1, 1, 0, 1, 0, 10000);
    play(8, 2, 1, 1, 5, 6, 7, 0, 0, 0, 10000);
    random_steps(20);
    settle();
    steady = 1'b0;

    configure(24'hFF_FFFF, SWING_MIN, $urandom, 40'd0);
    play(15, 4095, 1, 16, 90, 0, 111, 1, 0, 1, 10000);
    play(0, 1, 1, 0, 12, 0, 50, 0, 1, 0, 10000);
    random_steps(20);
    settle();

    // swing outside half a step gets clamped
    configure(LEN_W'($urandom_range(1, 20000)), 11'sh3FF, $urandom, 40'd12345);
    play(1, 3, 1, 2, 60, 0, 64, 0, 0, 0, 10000);
    random_steps(15);
    settle();

    configure(LEN_W'($urandom_range(1, 20000)), 11'sh400, $urandom, OFFS_W'($urandom));
    play(2, 4095, 1, 5, 61, 0, 65, 1, 1, 0, 10000);
    random_steps(15);
    settle();

    // zero step length plays nothing
    configure(24'd0, SWING_W'($urandom), $urandom, OFFS_W'($urandom));
    play(3, 4, 1, 4, 62, 0, 66, 0, 0, 1, 10000);
    random_steps(5);
    settle();

    repeat (2) begin
      random_config();
      steady = ($urandom_range(0, 3) == 0);
      random_steps(20);
      settle();
    end

    if (ledger.wrap_up()) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> step_sequencer_note_generator.f
sv/ssng_pkg.sv
sv/ssng_if.sv
sv/step_sequencer_note_generator.sv
dv/step_sequencer_note_generator_test.sv
